// ----- design/tdckf_pkg.sv -----
// Package for the time-of-day color keyframe interpolator.
// Holds the keyframe tables, configuration register indexes, segment reciprocals and the
// lane command type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tdckf_pkg;

  localparam int KEY_COUNT = 7;
  localparam int CHANNELS = 10;
  localparam int HALF_W = 6;

  // Reciprocals of the segment lengths, scaled by 2^RECIP_SHIFT and rounded up.
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W = 19;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HOUR = 1'b1;

  // Keyframe times in half hours.
  localparam logic [HALF_W-1:0] KEY_HALF [KEY_COUNT] = '{
    6'd0, 6'd10, 6'd13, 6'd24, 6'd35, 6'd38, 6'd48
  };

  // Zenith rgb, horizon rgb, ambient rgb, star level.
  localparam logic [7:0] KEY_VAL [KEY_COUNT][CHANNELS] = '{
    '{8'd10, 8'd10, 8'd25, 8'd5, 8'd5, 8'd15, 8'd20, 8'd20, 8'd35, 8'd255},
    '{8'd25, 8'd30, 8'd65, 8'd70, 8'd45, 8'd95, 8'd40, 8'd35, 8'd50, 8'd179},
    '{8'd40, 8'd80, 8'd140, 8'd245, 8'd130, 8'd60, 8'd130, 8'd90, 8'd80, 8'd0},
    '{8'd30, 8'd110, 8'd200, 8'd110, 8'd180, 8'd240, 8'd255, 8'd255, 8'd250, 8'd0},
    '{8'd50, 8'd60, 8'd120, 8'd230, 8'd90, 8'd40, 8'd140, 8'd90, 8'd80, 8'd26},
    '{8'd20, 8'd25, 8'd60, 8'd75, 8'd30, 8'd90, 8'd50, 8'd40, 8'd65, 8'd153},
    '{8'd10, 8'd10, 8'd25, 8'd5, 8'd5, 8'd15, 8'd20, 8'd20, 8'd35, 8'd255}
  };

  // The table only has segments of 3, 10 and 11 half hours. A zero span only comes
  // with a zero offset, where any reciprocal gives a zero quotient.
  function automatic logic [RECIP_W-1:0] recip_of(input logic [HALF_W-1:0] span);
    case (span)
      6'd3:    return RECIP_W'(349526);
      6'd10:   return RECIP_W'(104858);
      6'd11:   return RECIP_W'(95326);
      default: return '0;
    endcase
  endfunction

  typedef struct packed {
    logic load;
    logic mul;
    logic step;
  } lane_cmd_t;

endpackage

`default_nettype wire

// ----- design/tdckf_if.sv -----
// Valid/ready channel interfaces for the time-of-day color keyframe interpolator.
// The result interface width follows the hour format; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface tdckf_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] elapsed_time;

  modport source (output valid, output elapsed_time, input ready);
  modport sink (input valid, input elapsed_time, output ready);
endinterface

interface tdckf_out_if #(
  parameter int HOUR_BITS = 21
);
  logic                 valid;
  logic                 ready;
  logic [HOUR_BITS-1:0] hour_now;
  logic [7:0]           zenith_red;
  logic [7:0]           zenith_green;
  logic [7:0]           zenith_blue;
  logic [7:0]           horizon_red;
  logic [7:0]           horizon_green;
  logic [7:0]           horizon_blue;
  logic [7:0]           ambient_red;
  logic [7:0]           ambient_green;
  logic [7:0]           ambient_blue;
  logic [7:0]           star_level;

  modport source (
    output valid, output hour_now,
    output zenith_red, output zenith_green, output zenith_blue,
    output horizon_red, output horizon_green, output horizon_blue,
    output ambient_red, output ambient_green, output ambient_blue,
    output star_level, input ready
  );
  modport sink (
    input valid, input hour_now,
    input zenith_red, input zenith_green, input zenith_blue,
    input horizon_red, input horizon_green, input horizon_blue,
    input ambient_red, input ambient_green, input ambient_blue,
    input star_level, output ready
  );
endinterface

`default_nettype wire

// ----- design/tdckf_lane.sv -----
// One interpolation lane: c1 + floor((c2 - c1) * off / len) for a single channel.
// Multiplies once, then divides by the segment length through a reciprocal. Uses tdckf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdckf_lane import tdckf_pkg::*; #(
  parameter int OFF_W = 19,
  parameter int SPAN_SHIFT = 15
) (
  input  wire logic              clk,
  input  wire lane_cmd_t         cmd,
  input  wire logic [7:0]        c1,
  input  wire logic [7:0]        c2,
  input  wire logic [OFF_W-1:0]  off,
  input  wire logic [HALF_W-1:0] span,
  output logic      [7:0]        result
);

  localparam int NUM_W = OFF_W + 8;
  localparam int T_W = NUM_W - SPAN_SHIFT;
  localparam int QP_W = T_W + RECIP_W;

  logic [7:0]        c1_r;
  logic              neg_r;
  logic [7:0]        mag_r;
  logic [OFF_W-1:0]  off_r;
  logic [HALF_W-1:0] span_r;
  logic [NUM_W-1:0]  prod_r;
  logic [T_W-1:0]    t_r;
  logic              low_nz_r;
  logic [7:0]        quot_r;
  logic [T_W-1:0]    t_nxt;
  logic [QP_W-1:0]   qprod_nxt;
  logic [T_W-1:0]    back;
  logic              rem_nz;

  // The segment length is span half hours, so the low bits of the product divide out
  // by a shift and only the small span is left for the reciprocal.
  assign t_nxt = prod_r[NUM_W-1:SPAN_SHIFT];
  assign qprod_nxt = QP_W'(t_nxt) * QP_W'(recip_of(span_r));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c1_r   <= c1;
      neg_r  <= c2 < c1;
      mag_r  <= (c2 < c1) ? c1 - c2 : c2 - c1;
      off_r  <= off;
      span_r <= span;
    end
    if (cmd.mul) begin
      prod_r <= NUM_W'(mag_r) * NUM_W'(off_r);
    end
    if (cmd.step) begin
      // The offset never exceeds the length, so the quotient fits in eight bits.
      quot_r   <= qprod_nxt[RECIP_SHIFT+7:RECIP_SHIFT];
      t_r      <= t_nxt;
      low_nz_r <= prod_r[SPAN_SHIFT-1:0] != '0;
    end
  end

  // A negative slope rounds toward minus infinity, so a nonzero remainder takes one more.
  always_comb begin
    back   = T_W'(quot_r) * T_W'(span_r);
    rem_nz = low_nz_r || (back != t_r);
    if (neg_r) begin
      result = c1_r - quot_r - 8'(rem_nz);
    end else begin
      result = c1_r + quot_r;
    end
  end

endmodule

`default_nettype wire

// ----- design/time_of_day_color_keyframe_interp_unit.sv -----
// Time-of-day color keyframe interpolator, top level. Uses tdckf_pkg, tdckf_if, tdckf_lane.
// Holds the accumulator store, the configuration registers and the sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Each input transaction carries the elapsed time of one tick; the block advances the
// time-of-day accumulator by elapsed * speed, wraps once at 24 hours and returns the
// interpolated zenith, horizon and ambient colors and the star level. An item passes
// through these steps before the block can accept the next one: the acceptance
// cycle, the product of elapsed time and speed, the add through the one-entry
// accumulator store, the wrap and write back, segment selection, one lane multiply,
// one reciprocal multiply in the ten parallel lanes, and the load of the output
// register. The load waits while the previous result is still unaccepted. The output
// register lets the next transaction be accepted while a result waits. Writing
// start_hour loads the accumulator directly.

module time_of_day_color_keyframe_interp_unit import tdckf_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  tdckf_in_if.sink                          in_ch,
  tdckf_out_if.source                       out_ch,
  input  wire logic                         cfg_we,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [FRACTION_BITS+4:0]     cfg_data
);

  localparam int HB = FRACTION_BITS + 5;
  localparam int OFF_W = FRACTION_BITS + 3;
  localparam logic [HB:0] FULL_DAY = (HB+1)'(48) << (FRACTION_BITS - 1);
  localparam logic [HB-1:0] SPEED_RESET = HB'(((2 ** FRACTION_BITS) * 5 + 500) / 1000);
  localparam logic [HB-1:0] START_RESET = HB'(12) << (FRACTION_BITS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_ADD, S_WRAP, S_SEG, S_LMUL, S_DIV, S_FIN
  } state_t;

  state_t            state_r;
  logic              out_valid_r;
  logic [HB-1:0]     out_hour_r;
  logic [7:0]        out_chan_r [CHANNELS];

  logic [15:0]       elapsed_r;
  logic [HB-1:0]     speed_r;
  logic [HB-1:0]     acc_mem_r;
  logic [HB-1:0]     acc_rd_r;
  logic [HB-1:0]     inc_r;
  logic [HB:0]       sum_r;
  logic [HB-1:0]     h_r;
  logic [HB-1:0]     h_nxt;
  logic [HB+15:0]    prod_nxt;

  logic [HB-1:0]     key_time [KEY_COUNT];
  logic [2:0]        seg_lo;
  logic [2:0]        seg_hi;
  logic              seg_valid;
  logic [OFF_W-1:0]  seg_off;
  logic [HALF_W-1:0] seg_span;

  lane_cmd_t         cmd;
  logic [7:0]        lane_res [CHANNELS];

  logic              in_acc;
  logic              out_load;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign out_load = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  // Configuration registers and the accumulator store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r   <= SPEED_RESET;
      acc_mem_r <= START_RESET;
    end else begin
      if (cfg_we && cfg_index == CFG_SPEED) begin
        speed_r <= cfg_data;
      end
      if (cfg_we && cfg_index == CFG_START_HOUR) begin
        acc_mem_r <= cfg_data;
      end else if (state_r == S_WRAP) begin
        acc_mem_r <= h_nxt;
      end
    end
  end

  // Registered read port of the accumulator store.
  always_ff @(posedge clk) begin
    acc_rd_r <= acc_mem_r;
  end

  assign prod_nxt = (HB+16)'(elapsed_r) * (HB+16)'(speed_r);

  always_comb begin
    if (sum_r >= FULL_DAY) begin
      h_nxt = HB'(sum_r - FULL_DAY);
    end else begin
      h_nxt = sum_r[HB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      elapsed_r <= in_ch.elapsed_time;
    end
    if (state_r == S_MUL) begin
      inc_r <= prod_nxt[HB+15:16];
    end
    if (state_r == S_ADD) begin
      sum_r <= (HB+1)'(acc_rd_r) + (HB+1)'(inc_r);
    end
    if (state_r == S_WRAP) begin
      h_r <= h_nxt;
    end
  end

  // Segment selection: the first segment whose end is not below the hour, so a
  // keyframe time falls into the earlier segment.
  always_comb begin
    for (int i = 0; i < KEY_COUNT; i++) begin
      key_time[i] = HB'(KEY_HALF[i]) << (FRACTION_BITS - 1);
    end
    seg_lo = '0;
    seg_hi = '0;
    seg_valid = 1'b0;
    for (int i = KEY_COUNT - 2; i >= 0; i--) begin
      if (h_r <= key_time[i+1]) begin
        seg_lo = 3'(i);
        seg_hi = 3'(i + 1);
        seg_valid = 1'b1;
      end
    end
    if (seg_valid) begin
      seg_off  = OFF_W'(h_r - key_time[seg_lo]);
      seg_span = KEY_HALF[seg_hi] - KEY_HALF[seg_lo];
    end else begin
      // Beyond a full day the midnight keyframe is shown unchanged.
      seg_off  = '0;
      seg_span = KEY_HALF[1];
    end
  end

  always_comb begin
    cmd.load = (state_r == S_SEG);
    cmd.mul  = (state_r == S_LMUL);
    cmd.step = (state_r == S_DIV);
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    tdckf_lane #(
      .OFF_W      (OFF_W),
      .SPAN_SHIFT (FRACTION_BITS - 1)
    ) u_lane (
      .clk    (clk),
      .cmd    (cmd),
      .c1     (KEY_VAL[seg_lo][c]),
      .c2     (KEY_VAL[seg_hi][c]),
      .off    (seg_off),
      .span   (seg_span),
      .result (lane_res[c])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_MUL;
          end
        end
        S_MUL:  state_r <= S_ADD;
        S_ADD:  state_r <= S_WRAP;
        S_WRAP: state_r <= S_SEG;
        S_SEG:  state_r <= S_LMUL;
        S_LMUL: state_r <= S_DIV;
        S_DIV:  state_r <= S_FIN;
        S_FIN: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            out_hour_r  <= h_r;
            for (int c = 0; c < CHANNELS; c++) begin
              out_chan_r[c] <= lane_res[c];
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.hour_now      = out_hour_r;
  assign out_ch.zenith_red    = out_chan_r[0];
  assign out_ch.zenith_green  = out_chan_r[1];
  assign out_ch.zenith_blue   = out_chan_r[2];
  assign out_ch.horizon_red   = out_chan_r[3];
  assign out_ch.horizon_green = out_chan_r[4];
  assign out_ch.horizon_blue  = out_chan_r[5];
  assign out_ch.ambient_red   = out_chan_r[6];
  assign out_ch.ambient_green = out_chan_r[7];
  assign out_ch.ambient_blue  = out_chan_r[8];
  assign out_ch.star_level    = out_chan_r[9];

`ifndef SYNTH
  // A fresh result reports the hour that was just written back to the store.
  a_hour_written: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> out_hour_r == acc_mem_r)
    else $error("result hour differs from stored accumulator");

  // Any hour within the day must land in some keyframe segment.
  a_seg_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEG && (HB+1)'(h_r) < FULL_DAY) |-> seg_valid)
    else $error("no segment found for an in-range hour");

  // The sequencer goes straight from the quotient step to the final state.
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |=> state_r == S_FIN)
    else $error("quotient step length mismatch");

  // Only one transaction is in flight at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("input accepted while busy");
`endif

endmodule

`default_nettype wire
